// File: rtl/ccb_pkg.sv
package ccb_pkg;

    localparam int TALLY_W = 21;
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    localparam int LEVEL_W = 8;
    localparam int RATIO_W = 12;
    localparam int AREA_W  = 21;
    localparam int INDEX_W = 4;
    localparam int DATA_W  = 21;
    localparam int CLASS_W = 2;

    // Box class codes.
    localparam logic [CLASS_W-1:0] CLASS_NONE      = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_BARREL    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_CROCODILE = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_REJECTED  = 2'd3;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_RED_LEVEL    = 4'd0;
    localparam logic [INDEX_W-1:0] REG_RED_MARGIN   = 4'd1;
    localparam logic [INDEX_W-1:0] REG_GREEN_LEVEL  = 4'd2;
    localparam logic [INDEX_W-1:0] REG_GREEN_MARGIN = 4'd3;
    localparam logic [INDEX_W-1:0] REG_RATIO_LOW    = 4'd4;
    localparam logic [INDEX_W-1:0] REG_RATIO_HIGH   = 4'd5;
    localparam logic [INDEX_W-1:0] REG_AREA_LOW     = 4'd6;
    localparam logic [INDEX_W-1:0] REG_AREA_HIGH    = 4'd7;

    localparam logic [LEVEL_W-1:0] RST_RED_LEVEL    = 8'd100;
    localparam logic [LEVEL_W-1:0] RST_RED_MARGIN   = 8'd50;
    localparam logic [LEVEL_W-1:0] RST_GREEN_LEVEL  = 8'd100;
    localparam logic [LEVEL_W-1:0] RST_GREEN_MARGIN = 8'd50;
    localparam logic [RATIO_W-1:0] RST_RATIO_LOW    = 12'd128;
    localparam logic [RATIO_W-1:0] RST_RATIO_HIGH   = 12'd512;
    localparam logic [AREA_W-1:0]  RST_AREA_LOW     = 21'd100;
    localparam logic [AREA_W-1:0]  RST_AREA_HIGH    = 21'd400000;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] red_margin;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] green_margin;
        logic [RATIO_W-1:0] ratio_low;
        logic [RATIO_W-1:0] ratio_high;
        logic [AREA_W-1:0]  area_low;
        logic [AREA_W-1:0]  area_high;
    } cfg_regs_t;

endpackage

// File: rtl/ccb_fifo.sv
module ccb_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/ccb_front.sv
module ccb_front import ccb_pkg::*; #(
    parameter int MAX_SIDE = 1024,
    parameter int SIDE_W   = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_regs_t                     cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    blue,
    input  logic [7:0]                    green,
    input  logic [7:0]                    red,
    input  logic [10:0]                   box_width,
    input  logic [10:0]                   box_height,
    input  logic                          last_pixel,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [2*TALLY_W+2*SIDE_W-1:0] q_data
);

    localparam int EXT_W = (SIDE_W > 11) ? SIDE_W : 11;
    localparam logic [EXT_W-1:0] SIDE_LIM = EXT_W'(MAX_SIDE);

    logic [TALLY_W-1:0] red_tally_reg, red_tally_next;
    logic [TALLY_W-1:0] green_tally_reg, green_tally_next;
    logic [TALLY_W-1:0] red_count, green_count;
    logic               red_hit, green_hit, accept;
    logic [EXT_W-1:0]   w_ext, h_ext;
    logic [SIDE_W-1:0]  w_side, h_side;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign red_hit   = (red > cfg.red_level)
                    && ({1'b0, red} > {1'b0, green} + {1'b0, cfg.red_margin});
    assign green_hit = (green > cfg.green_level)
                    && ({1'b0, green} > {1'b0, blue} + {1'b0, cfg.green_margin});

    // Counts saturate instead of wrapping.
    assign red_count   = (red_hit && red_tally_reg != TALLY_MAX)
                       ? red_tally_reg + 1'b1 : red_tally_reg;
    assign green_count = (green_hit && green_tally_reg != TALLY_MAX)
                       ? green_tally_reg + 1'b1 : green_tally_reg;

    assign w_ext  = EXT_W'(box_width);
    assign h_ext  = EXT_W'(box_height);
    assign w_side = SIDE_W'((w_ext > SIDE_LIM) ? SIDE_LIM : w_ext);
    assign h_side = SIDE_W'((h_ext > SIDE_LIM) ? SIDE_LIM : h_ext);

    assign q_push = accept && last_pixel;
    assign q_data = {red_count, green_count, w_side, h_side};

    always_comb
    begin
        red_tally_next   = red_tally_reg;
        green_tally_next = green_tally_reg;
        if (accept)
        begin
            red_tally_next   = last_pixel ? '0 : red_count;
            green_tally_next = last_pixel ? '0 : green_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_tally_reg   <= '0;
            green_tally_reg <= '0;
        end
        else
        begin
            red_tally_reg   <= red_tally_next;
            green_tally_reg <= green_tally_next;
        end
    end

endmodule

// File: rtl/ccb_back.sv
module ccb_back import ccb_pkg::*; #(
    parameter int SIDE_W = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_regs_t                     cfg,
    input  logic                          q_empty,
    input  logic [2*TALLY_W+2*SIDE_W-1:0] q_data,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [CLASS_W-1:0]            box_class,
    output logic [TALLY_W-1:0]            red_total,
    output logic [TALLY_W-1:0]            green_total
);

    localparam int AR_W  = 2 * SIDE_W;
    localparam int RP_W  = RATIO_W + SIDE_W;
    localparam int CMP_W = (AR_W > AREA_W) ? AR_W : AREA_W;

    logic [TALLY_W-1:0] q_red, q_green;
    logic [SIDE_W-1:0]  q_w, q_h;

    logic               a_vld_reg, a_vld_next;
    logic [TALLY_W-1:0] a_red_reg, a_green_reg;
    logic [AR_W-1:0]    a_area_reg;
    logic [RP_W-1:0]    a_lo_reg, a_hi_reg, a_w256_reg;

    logic               out_vld_reg, out_vld_next;
    logic [CLASS_W-1:0] class_reg, class_next;
    logic [TALLY_W-1:0] red_reg, green_reg;

    logic               adv_b, load_a;
    logic [CMP_W-1:0]   area_x, thresh_x;
    logic               area_bad, ratio_bad, red_win, green_win;

    assign {q_red, q_green, q_w, q_h} = q_data;

    assign adv_b  = !out_vld_reg || out_ready;
    assign load_a = !a_vld_reg || adv_b;
    assign q_pop  = load_a && !q_empty;

    // Second stage: window and ratio compares against the products.
    assign area_x    = CMP_W'(a_area_reg);
    assign thresh_x  = area_x >> 2;
    assign area_bad  = (area_x > CMP_W'(cfg.area_high)) || (area_x < CMP_W'(cfg.area_low));
    assign ratio_bad = (a_w256_reg < a_lo_reg) || (a_w256_reg > a_hi_reg);
    assign red_win   = (a_red_reg != '0) && (CMP_W'(a_red_reg) > thresh_x);
    assign green_win = (a_green_reg != '0) && (CMP_W'(a_green_reg) > thresh_x);

    always_comb
    begin
        if (area_bad)
        begin
            class_next = CLASS_REJECTED;
        end
        else if (ratio_bad)
        begin
            class_next = CLASS_NONE;
        end
        else if (red_win)
        begin
            class_next = CLASS_BARREL;
        end
        else if (green_win)
        begin
            class_next = CLASS_CROCODILE;
        end
        else
        begin
            class_next = CLASS_NONE;
        end
    end

    always_comb
    begin
        a_vld_next   = load_a ? !q_empty : a_vld_reg;
        out_vld_next = adv_b ? a_vld_reg : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg   <= a_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // First stage: area and the two ratio bounds scaled by the height.
    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_red_reg   <= q_red;
            a_green_reg <= q_green;
            a_area_reg  <= AR_W'(q_w) * AR_W'(q_h);
            a_lo_reg    <= RP_W'(cfg.ratio_low) * RP_W'(q_h);
            a_hi_reg    <= RP_W'(cfg.ratio_high) * RP_W'(q_h);
            a_w256_reg  <= RP_W'({q_w, 8'h00});
        end
        if (adv_b)
        begin
            class_reg <= class_next;
            red_reg   <= a_red_reg;
            green_reg <= a_green_reg;
        end
    end

    assign out_valid   = out_vld_reg;
    assign box_class   = class_reg;
    assign red_total   = red_reg;
    assign green_total = green_reg;

endmodule

// File: rtl/color_box_classifier.sv
// Color box classifier: counts red- and green-dominant pixels of a box, classifies at its last pixel.
// Throughput: one pixel word per cycle while the result queue is not full; a box result can
// leave every cycle while out_ready is high. After the last pixel is accepted, the result word
// passes the queue write, the product stage and the compare stage into the output register.
// Reset clears the counts, the result queue and all valid flags, and loads the
// configuration registers with their default values.
module color_box_classifier import ccb_pkg::*; #(
    parameter int MAX_SIDE = 1024,
    parameter int Q_DEPTH  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         blue,
    input  logic [7:0]         green,
    input  logic [7:0]         red,
    input  logic [10:0]        box_width,
    input  logic [10:0]        box_height,
    input  logic               last_pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CLASS_W-1:0] box_class,
    output logic [TALLY_W-1:0] red_total,
    output logic [TALLY_W-1:0] green_total
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int REC_W  = 2 * TALLY_W + 2 * SIDE_W;

    cfg_regs_t        cfg_reg, cfg_next;
    logic             q_push, q_pop, q_full, q_empty;
    logic [REC_W-1:0] q_wdata, q_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_RED_LEVEL:    cfg_next.red_level    = cfg_data[LEVEL_W-1:0];
                REG_RED_MARGIN:   cfg_next.red_margin   = cfg_data[LEVEL_W-1:0];
                REG_GREEN_LEVEL:  cfg_next.green_level  = cfg_data[LEVEL_W-1:0];
                REG_GREEN_MARGIN: cfg_next.green_margin = cfg_data[LEVEL_W-1:0];
                REG_RATIO_LOW:    cfg_next.ratio_low    = cfg_data[RATIO_W-1:0];
                REG_RATIO_HIGH:   cfg_next.ratio_high   = cfg_data[RATIO_W-1:0];
                REG_AREA_LOW:     cfg_next.area_low     = cfg_data[AREA_W-1:0];
                REG_AREA_HIGH:    cfg_next.area_high    = cfg_data[AREA_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_level    <= RST_RED_LEVEL;
            cfg_reg.red_margin   <= RST_RED_MARGIN;
            cfg_reg.green_level  <= RST_GREEN_LEVEL;
            cfg_reg.green_margin <= RST_GREEN_MARGIN;
            cfg_reg.ratio_low    <= RST_RATIO_LOW;
            cfg_reg.ratio_high   <= RST_RATIO_HIGH;
            cfg_reg.area_low     <= RST_AREA_LOW;
            cfg_reg.area_high    <= RST_AREA_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ccb_front #(
        .MAX_SIDE (MAX_SIDE),
        .SIDE_W   (SIDE_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .box_width  (box_width),
        .box_height (box_height),
        .last_pixel (last_pixel),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    ccb_fifo #(
        .WIDTH (REC_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    ccb_back #(
        .SIDE_W (SIDE_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .box_class   (box_class),
        .red_total   (red_total),
        .green_total (green_total)
    );

endmodule
